>>> sv/l4he_pkg.sv
// ----------------------------------------------------------------------------
// l4he_pkg
// Shared types and constants of the L4 header extractor: channel payloads,
// the end-of-packet snapshot, link type, ethertype and protocol codes.
// ----------------------------------------------------------------------------
package l4he_pkg;

  // Capture and length limits
  localparam logic [15:0] MAX_PACKET_BYTES = 16'hFFFF;

  // pcap link types
  localparam logic [15:0] LT_NULL     = 16'd0;
  localparam logic [15:0] LT_ETHERNET = 16'd1;
  localparam logic [15:0] LT_RAW      = 16'd101;
  localparam logic [15:0] LT_IPV4     = 16'd228;
  localparam logic [15:0] LT_IPV6     = 16'd229;

  // Ethertypes
  localparam logic [15:0] ET_VLAN = 16'h8100;
  localparam logic [15:0] ET_IPV6 = 16'h86DD;
  localparam logic [15:0] ET_IPV4 = 16'h0800;

  // BSD null address families
  localparam logic [31:0] AF_INET           = 32'd2;
  localparam logic [31:0] AF_INET6_BSD      = 32'd24;
  localparam logic [31:0] AF_INET6_FREEBSD  = 32'd28;
  localparam logic [31:0] AF_INET6_DARWIN   = 32'd30;

  // Link header lengths
  localparam logic [4:0] NULL_HDR_LEN     = 5'd4;
  localparam logic [4:0] ETH_HDR_LEN      = 5'd14;
  localparam logic [4:0] ETH_VLAN_HDR_LEN = 5'd18;

  // Network and transport header lengths
  localparam logic [5:0] IPV4_MIN_HDR_LEN = 6'd20;
  localparam logic [7:0] IPV6_HDR_LEN     = 8'd40;
  localparam logic [5:0] TCP_MIN_HDR_LEN  = 6'd20;
  localparam logic [7:0] UDP_HDR_LEN      = 8'd8;

  // IP protocol numbers
  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  typedef enum logic [1:0] {
    IP_NONE,
    IP_V4,
    IP_V6
  } ip_kind_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic [15:0] link_type;
    logic        last_byte;
  } hdr_in_t;

  typedef struct packed {
    logic        parse_ok;
    logic [7:0]  ip_protocol;
    logic [31:0] source_address;
    logic [31:0] dest_address;
    logic [15:0] source_port;
    logic [15:0] dest_port;
    logic [31:0] tcp_sequence;
    logic [7:0]  tcp_flag_bits;
    logic [7:0]  payload_offset;
    logic [15:0] payload_length;
  } hdr_out_t;

  // Header fields as captured up to and including the last byte of a packet
  typedef struct packed {
    logic [15:0] pkt_len;
    ip_kind_e    kind;
    logic [4:0]  ip_start;
    logic [5:0]  ip_hdr_len;
    logic [5:0]  tcp_hdr_len;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [31:0] tcp_seq;
    logic [7:0]  tcp_flags;
  } snap_t;

endpackage

>>> sv/l4_header_extractor.sv
// ----------------------------------------------------------------------------
// l4_header_extractor
// Streaming header parser: takes one captured packet byte per transaction
// and gives one five-tuple record per packet, after its last byte.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                 Payload
//   in        input      in_valid_i / in_ready_o   in_data_i  (hdr_in_t)
//   out       output     out_valid_o / out_ready_i out_data_o (hdr_out_t)
//
// One byte per cycle sustained while the input is not stalled; each byte
// updates the field registers. The last byte loads a snapshot register; the
// checks run between it and the output register, which loads when free.
// Reset clears the byte position, the captured fields and the valid flags.
// A stalled output holds the record; input stalls only while the snapshot and
// the output register are both full and the output is stalled.
module l4_header_extractor (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  l4he_pkg::hdr_in_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output l4he_pkg::hdr_out_t out_data_o
);

  logic               in_fire;
  logic               out_load;
  logic               snap_valid_q, snap_valid_d;
  l4he_pkg::snap_t    snap;
  l4he_pkg::snap_t    snap_q;
  l4he_pkg::hdr_out_t rec;
  logic               out_valid_q, out_valid_d;
  l4he_pkg::hdr_out_t out_q;

  assign out_load   = snap_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !snap_valid_q || out_load;
  assign in_fire    = in_valid_i && in_ready_o;

  l4he_capture u_capture (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .byte_valid_i (in_fire),
    .byte_i       (in_data_i),
    .snap_o       (snap)
  );

  l4he_eval u_eval (
    .snap_i (snap_q),
    .rec_o  (rec)
  );

  always_comb begin
    snap_valid_d = snap_valid_q;
    if (out_load) begin
      snap_valid_d = 1'b0;
    end
    if (in_fire && in_data_i.last_byte) begin
      snap_valid_d = 1'b1;
    end

    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      snap_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      snap_valid_q <= snap_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Payload registers: load on transfer, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_fire && in_data_i.last_byte) begin
      snap_q <= snap;
    end
    if (out_load) begin
      out_q <= rec;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  a_ok_is_transport: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.parse_ok |->
      (out_data_o.ip_protocol == l4he_pkg::PROTO_TCP ||
       out_data_o.ip_protocol == l4he_pkg::PROTO_UDP))
    else $error("parse_ok set for a non-transport protocol");

  a_fail_clears_l4: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.parse_ok |->
      (out_data_o.source_port == 16'd0 && out_data_o.dest_port == 16'd0 &&
       out_data_o.payload_offset == 8'd0 && out_data_o.payload_length == 16'd0))
    else $error("transport fields set on a failed record");

  a_flags_only_tcp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tcp_flag_bits != 8'd0 |->
      out_data_o.ip_protocol == l4he_pkg::PROTO_TCP)
    else $error("TCP flags reported on a non-TCP record");

  a_min_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.parse_ok |-> out_data_o.payload_offset >= 8'd28)
    else $error("payload offset below smallest transport header end");

  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> snap_valid_q && out_valid_q && !out_ready_i)
    else $error("input stalled with room in the pipeline");

  a_record_follows_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.last_byte |=> snap_valid_q)
    else $error("last byte did not load the snapshot");
`endif

endmodule

>>> sv/l4he_capture.sv
// ----------------------------------------------------------------------------
// l4he_capture
// Per-byte field capture: tracks the byte position in the packet, decodes
// the link layer and latches IP and transport header fields as they pass.
// ----------------------------------------------------------------------------
module l4he_capture (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              byte_valid_i,
  input  l4he_pkg::hdr_in_t byte_i,
  output l4he_pkg::snap_t   snap_o
);

  logic [15:0]        cnt_q, cnt_d;
  logic [15:0]        lt_q, lt_d;
  l4he_pkg::ip_kind_e kind_q, kind_d;
  logic               vlan_q, vlan_d;
  logic [4:0]         ip_start_q, ip_start_d;
  logic [5:0]         ihl_q, ihl_d;
  logic [7:0]         l4_start_q, l4_start_d;
  logic [5:0]         doff_q, doff_d;
  logic [7:0]         proto_q, proto_d;
  logic [31:0]        src_q, src_d;
  logic [31:0]        dst_q, dst_d;
  logic [15:0]        sport_q, sport_d;
  logic [15:0]        dport_q, dport_d;
  logic [31:0]        seq_q, seq_d;
  logic [7:0]         flags_q, flags_d;
  logic [31:0]        shift_q, shift_d;

  logic        take;
  logic        first;
  logic        in_win;
  logic [7:0]  pos;
  logic [15:0] lt_cur;
  logic [4:0]  ip_start_cur;
  logic        ip_hit;
  logic [7:0]  ip_rel;
  logic        l4_hit;
  logic [7:0]  l4_rel;
  logic [31:0] word;
  logic [31:0] null_af;
  logic [15:0] pkt_len;

  function automatic logic [4:0] link_hdr_len(input logic [15:0] lt);
    logic [4:0] len;
    unique case (lt) inside
      l4he_pkg::LT_ETHERNET: len = l4he_pkg::ETH_HDR_LEN;
      l4he_pkg::LT_NULL:     len = l4he_pkg::NULL_HDR_LEN;
      default:               len = 5'd0;
    endcase
    return len;
  endfunction

  // Kind known from the first byte; Ethernet and null decide later
  function automatic l4he_pkg::ip_kind_e first_kind(input logic [15:0] lt,
                                                    input logic [7:0]  b);
    l4he_pkg::ip_kind_e k;
    unique case (lt) inside
      l4he_pkg::LT_RAW, l4he_pkg::LT_IPV4, l4he_pkg::LT_IPV6:
        k = (b[7:4] == 4'd6) ? l4he_pkg::IP_V6 : l4he_pkg::IP_V4;
      l4he_pkg::LT_ETHERNET, l4he_pkg::LT_NULL:
        k = l4he_pkg::IP_NONE;
      default:
        k = (b[7:4] == 4'd4) ? l4he_pkg::IP_V4 : l4he_pkg::IP_NONE;
    endcase
    return k;
  endfunction

  function automatic l4he_pkg::ip_kind_e et_kind(input logic [15:0] et);
    l4he_pkg::ip_kind_e k;
    unique case (et) inside
      l4he_pkg::ET_IPV4: k = l4he_pkg::IP_V4;
      l4he_pkg::ET_IPV6: k = l4he_pkg::IP_V6;
      default:           k = l4he_pkg::IP_NONE;
    endcase
    return k;
  endfunction

  function automatic l4he_pkg::ip_kind_e af_kind(input logic [31:0] af);
    l4he_pkg::ip_kind_e k;
    unique case (af) inside
      l4he_pkg::AF_INET:
        k = l4he_pkg::IP_V4;
      l4he_pkg::AF_INET6_BSD, l4he_pkg::AF_INET6_FREEBSD, l4he_pkg::AF_INET6_DARWIN:
        k = l4he_pkg::IP_V6;
      default:
        k = l4he_pkg::IP_NONE;
    endcase
    return k;
  endfunction

  assign take         = byte_valid_i && (cnt_q != l4he_pkg::MAX_PACKET_BYTES);
  assign first        = (cnt_q == 16'd0);
  assign in_win       = (cnt_q[15:8] == 8'd0);
  assign pos          = cnt_q[7:0];
  assign lt_cur       = first ? byte_i.link_type : lt_q;
  assign ip_start_cur = first ? link_hdr_len(byte_i.link_type) : ip_start_q;
  assign ip_rel       = pos - {3'd0, ip_start_cur};
  assign ip_hit       = in_win && (pos >= {3'd0, ip_start_cur});
  assign l4_rel       = pos - l4_start_q;
  assign l4_hit       = in_win && (pos >= l4_start_q);
  assign word         = {shift_q[23:0], byte_i.data_byte};
  // Null link family is little-endian over the first four bytes
  assign null_af      = {byte_i.data_byte, shift_q[7:0], shift_q[15:8], shift_q[23:16]};
  assign pkt_len      = take ? (cnt_q + 16'd1) : cnt_q;

  always_comb begin
    cnt_d      = cnt_q;
    lt_d       = lt_q;
    kind_d     = kind_q;
    vlan_d     = vlan_q;
    ip_start_d = ip_start_q;
    ihl_d      = ihl_q;
    l4_start_d = l4_start_q;
    doff_d     = doff_q;
    proto_d    = proto_q;
    src_d      = src_q;
    dst_d      = dst_q;
    sport_d    = sport_q;
    dport_d    = dport_q;
    seq_d      = seq_q;
    flags_d    = flags_q;
    shift_d    = shift_q;

    if (take) begin
      cnt_d   = cnt_q + 16'd1;
      shift_d = word;

      if (first) begin
        lt_d       = byte_i.link_type;
        ip_start_d = link_hdr_len(byte_i.link_type);
        kind_d     = first_kind(byte_i.link_type, byte_i.data_byte);
        vlan_d     = 1'b0;
        l4_start_d = '1;
      end

      if (in_win && lt_cur == l4he_pkg::LT_ETHERNET) begin
        if (pos == 8'd13) begin
          vlan_d = (word[15:0] == l4he_pkg::ET_VLAN);
          kind_d = et_kind(word[15:0]);
          if (word[15:0] == l4he_pkg::ET_VLAN) begin
            ip_start_d = l4he_pkg::ETH_VLAN_HDR_LEN;
          end
        end
        if (pos == 8'd17 && vlan_q) begin
          kind_d = et_kind(word[15:0]);
        end
      end

      if (in_win && lt_cur == l4he_pkg::LT_NULL && pos == 8'd3) begin
        kind_d = af_kind(null_af);
      end

      // Network header, by offset from its start
      if (ip_hit) begin
        case (ip_rel)
          8'd0: ihl_d = {byte_i.data_byte[3:0], 2'b00};
          8'd1: l4_start_d = {3'd0, ip_start_cur} +
                             ((kind_q == l4he_pkg::IP_V6) ? l4he_pkg::IPV6_HDR_LEN
                                                          : {2'd0, ihl_q});
          8'd6: if (kind_q == l4he_pkg::IP_V6) proto_d = byte_i.data_byte;
          8'd9: if (kind_q == l4he_pkg::IP_V4) proto_d = byte_i.data_byte;
          8'd11: if (kind_q == l4he_pkg::IP_V6) src_d = word;
          8'd15: begin
            if (kind_q == l4he_pkg::IP_V4) src_d = word;
            if (kind_q == l4he_pkg::IP_V6) src_d = src_q ^ word;
          end
          8'd19: begin
            if (kind_q == l4he_pkg::IP_V4) dst_d = word;
            if (kind_q == l4he_pkg::IP_V6) src_d = src_q ^ word;
          end
          8'd23: if (kind_q == l4he_pkg::IP_V6) src_d = src_q ^ word;
          8'd27: if (kind_q == l4he_pkg::IP_V6) dst_d = word;
          8'd31, 8'd35, 8'd39: if (kind_q == l4he_pkg::IP_V6) dst_d = dst_q ^ word;
          default: ;
        endcase
      end

      // Transport header, by offset from its start
      if (l4_hit) begin
        case (l4_rel)
          8'd1:  sport_d = word[15:0];
          8'd3:  dport_d = word[15:0];
          8'd7:  seq_d   = word;
          8'd12: doff_d  = {byte_i.data_byte[7:4], 2'b00};
          8'd13: flags_d = byte_i.data_byte;
          default: ;
        endcase
      end
    end

    if (byte_valid_i && byte_i.last_byte) begin
      cnt_d = 16'd0;
    end
  end

  always_comb begin
    snap_o.pkt_len     = pkt_len;
    snap_o.kind        = kind_d;
    snap_o.ip_start    = ip_start_d;
    snap_o.ip_hdr_len  = ihl_d;
    snap_o.tcp_hdr_len = doff_d;
    snap_o.protocol    = proto_d;
    snap_o.src_addr    = src_d;
    snap_o.dst_addr    = dst_d;
    snap_o.src_port    = sport_d;
    snap_o.dst_port    = dport_d;
    snap_o.tcp_seq     = seq_d;
    snap_o.tcp_flags   = flags_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q      <= '0;
      lt_q       <= '0;
      kind_q     <= l4he_pkg::IP_NONE;
      vlan_q     <= 1'b0;
      ip_start_q <= '0;
      ihl_q      <= '0;
      l4_start_q <= '0;
      doff_q     <= '0;
      proto_q    <= '0;
      src_q      <= '0;
      dst_q      <= '0;
      sport_q    <= '0;
      dport_q    <= '0;
      seq_q      <= '0;
      flags_q    <= '0;
      shift_q    <= '0;
    end else begin
      cnt_q      <= cnt_d;
      lt_q       <= lt_d;
      kind_q     <= kind_d;
      vlan_q     <= vlan_d;
      ip_start_q <= ip_start_d;
      ihl_q      <= ihl_d;
      l4_start_q <= l4_start_d;
      doff_q     <= doff_d;
      proto_q    <= proto_d;
      src_q      <= src_d;
      dst_q      <= dst_d;
      sport_q    <= sport_d;
      dport_q    <= dport_d;
      seq_q      <= seq_d;
      flags_q    <= flags_d;
      shift_q    <= shift_d;
    end
  end

endmodule

>>> sv/l4he_eval.sv
// ----------------------------------------------------------------------------
// l4he_eval
// End-of-packet checks: applies the length checks of each layer to the
// captured fields and builds the result record.
// ----------------------------------------------------------------------------
module l4he_eval (
  input  l4he_pkg::snap_t    snap_i,
  output l4he_pkg::hdr_out_t rec_o
);

  logic [7:0]  l4_start;
  logic [15:0] l4_len;
  logic        v4_ok;
  logic        v6_ok;
  logic        ip_ok;
  logic        tcp_ok;
  logic        udp_ok;

  assign l4_start = {3'd0, snap_i.ip_start} +
                    ((snap_i.kind == l4he_pkg::IP_V6) ? l4he_pkg::IPV6_HDR_LEN
                                                      : {2'd0, snap_i.ip_hdr_len});

  assign v4_ok  = (snap_i.kind == l4he_pkg::IP_V4) &&
                  (snap_i.ip_hdr_len >= l4he_pkg::IPV4_MIN_HDR_LEN) &&
                  (snap_i.pkt_len >= {8'd0, l4_start});
  assign v6_ok  = (snap_i.kind == l4he_pkg::IP_V6) &&
                  (snap_i.pkt_len >= {8'd0, l4_start});
  assign ip_ok  = v4_ok || v6_ok;
  assign l4_len = snap_i.pkt_len - {8'd0, l4_start};

  assign tcp_ok = ip_ok && (snap_i.protocol == l4he_pkg::PROTO_TCP) &&
                  (l4_len >= {10'd0, l4he_pkg::TCP_MIN_HDR_LEN}) &&
                  (snap_i.tcp_hdr_len >= l4he_pkg::TCP_MIN_HDR_LEN) &&
                  ({10'd0, snap_i.tcp_hdr_len} <= l4_len);
  assign udp_ok = ip_ok && (snap_i.protocol == l4he_pkg::PROTO_UDP) &&
                  (l4_len >= {8'd0, l4he_pkg::UDP_HDR_LEN});

  always_comb begin
    rec_o = '0;
    if (ip_ok) begin
      rec_o.ip_protocol    = snap_i.protocol;
      rec_o.source_address = snap_i.src_addr;
      rec_o.dest_address   = snap_i.dst_addr;
    end
    if (tcp_ok) begin
      rec_o.parse_ok       = 1'b1;
      rec_o.source_port    = snap_i.src_port;
      rec_o.dest_port      = snap_i.dst_port;
      rec_o.tcp_sequence   = snap_i.tcp_seq;
      rec_o.tcp_flag_bits  = snap_i.tcp_flags;
      rec_o.payload_offset = l4_start + {2'd0, snap_i.tcp_hdr_len};
      rec_o.payload_length = l4_len - {10'd0, snap_i.tcp_hdr_len};
    end else if (udp_ok) begin
      rec_o.parse_ok       = 1'b1;
      rec_o.source_port    = snap_i.src_port;
      rec_o.dest_port      = snap_i.dst_port;
      rec_o.payload_offset = l4_start + l4he_pkg::UDP_HDR_LEN;
      rec_o.payload_length = l4_len - {8'd0, l4he_pkg::UDP_HDR_LEN};
    end
  end

endmodule

>>> bench/l4_header_extractor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// l4_header_extractor_test
// Streams captured packets into the extractor one byte per transaction and
// checks every record against a byte-level parser kept in the bench. Covers
// each link layer, the failed-check and other-protocol cases, header depth
// extremes, long output back-pressure and random traffic under several idle
// and stall mixes.
// ----------------------------------------------------------------------------
module l4_header_extractor_test;
  import l4he_pkg::*;

  localparam int unsigned HDR_DEPTH   = 138;
  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned DRAIN_TAIL  = 20;

  localparam logic [7:0]  PROTO_ICMP   = 8'd1;
  localparam logic [7:0]  PROTO_ICMPV6 = 8'd58;
  localparam logic [15:0] ET_ARP       = 16'h0806;
  localparam logic [31:0] AF_UNKNOWN   = 32'd7;

  typedef enum int {FILL_RANDOM, FILL_ONES, FILL_ZEROS} fill_e;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     out_ready = 1'b0;
  logic     hold_off  = 1'b0;
  hdr_in_t  in_data   = '0;
  logic     in_ready_o;
  logic     out_valid_o;
  hdr_out_t out_data_o;

  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  fill_e       fill_mode = FILL_RANDOM;

  // Packet under construction, and the expected records in arrival order
  logic [7:0] frame_bytes[$];
  hdr_out_t   pending_records[$];

  // Parser state: header bytes of the current packet, length, link type
  logic [7:0]  header_bytes[HDR_DEPTH];
  int unsigned captured_len = 0;
  logic [15:0] packet_link_type = '0;

  l4_header_extractor dut (
    .clk_i,
    .rst_ni,
    .in_valid_i (in_valid),
    .in_ready_o,
    .in_data_i  (in_data),
    .out_valid_o,
    .out_ready_i(out_ready),
    .out_data_o
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // --------------------------------------------------------------------------
  // Parser
  // --------------------------------------------------------------------------
  function automatic logic [15:0] be16(int unsigned i);
    return {header_bytes[i], header_bytes[i + 1]};
  endfunction

  function automatic logic [31:0] be32(int unsigned i);
    return {header_bytes[i], header_bytes[i + 1], header_bytes[i + 2], header_bytes[i + 3]};
  endfunction

  function automatic logic [31:0] fold_ipv6(int unsigned i);
    return be32(i) ^ be32(i + 4) ^ be32(i + 8) ^ be32(i + 12);
  endfunction

  function automatic hdr_out_t parse_five_tuple(int unsigned len, logic [15:0] lt);
    hdr_out_t    rec;
    logic [15:0] et;
    logic [31:0] family;
    logic [7:0]  proto;
    int unsigned off, ip, iplen, hl, l4len, doff;
    rec = '0;
    et = '0;
    off = 0;
    if (lt == LT_ETHERNET) begin
      if (len < ETH_HDR_LEN) return rec;
      et = be16(12);
      off = ETH_HDR_LEN;
      if (et == ET_VLAN) begin
        if (len < ETH_VLAN_HDR_LEN) return rec;
        et = be16(16);
        off = ETH_VLAN_HDR_LEN;
      end
    end else if (lt == LT_RAW || lt == LT_IPV4 || lt == LT_IPV6) begin
      et = (header_bytes[0][7:4] == 4'd6) ? ET_IPV6 : ET_IPV4;
    end else if (lt == LT_NULL) begin
      if (len < NULL_HDR_LEN) return rec;
      // address family is stored little-endian
      family = {header_bytes[3], header_bytes[2], header_bytes[1], header_bytes[0]};
      if (family == AF_INET) et = ET_IPV4;
      else if (family == AF_INET6_BSD || family == AF_INET6_FREEBSD ||
               family == AF_INET6_DARWIN) et = ET_IPV6;
      off = NULL_HDR_LEN;
    end else begin
      if (header_bytes[0][7:4] != 4'd4) return rec;
      et = ET_IPV4;
    end

    if (len < off) return rec;
    ip = off;
    iplen = len - off;
    if (et == ET_IPV4) begin
      if (iplen < IPV4_MIN_HDR_LEN) return rec;
      hl = int'(header_bytes[ip][3:0]) * 4;
      if (hl < IPV4_MIN_HDR_LEN || hl > iplen) return rec;
      proto = header_bytes[ip + 9];
      rec.source_address = be32(ip + 12);
      rec.dest_address   = be32(ip + 16);
      off += hl;
    end else if (et == ET_IPV6) begin
      if (iplen < IPV6_HDR_LEN) return rec;
      proto = header_bytes[ip + 6];
      rec.source_address = fold_ipv6(ip + 8);
      rec.dest_address   = fold_ipv6(ip + 24);
      off += IPV6_HDR_LEN;
    end else begin
      return rec;
    end

    if (len < off) return rec;
    l4len = len - off;
    rec.ip_protocol = proto;
    if (proto == PROTO_TCP) begin
      if (l4len < TCP_MIN_HDR_LEN) return rec;
      doff = int'(header_bytes[off + 12][7:4]) * 4;
      if (doff < TCP_MIN_HDR_LEN || doff > l4len) return rec;
      rec.source_port    = be16(off);
      rec.dest_port      = be16(off + 2);
      rec.tcp_sequence   = be32(off + 4);
      rec.tcp_flag_bits  = header_bytes[off + 13];
      rec.payload_offset = 8'(off + doff);
      rec.payload_length = 16'(l4len - doff);
      rec.parse_ok       = 1'b1;
    end else if (proto == PROTO_UDP) begin
      if (l4len < UDP_HDR_LEN) return rec;
      rec.source_port    = be16(off);
      rec.dest_port      = be16(off + 2);
      rec.payload_offset = 8'(off + UDP_HDR_LEN);
      rec.payload_length = 16'(l4len - UDP_HDR_LEN);
      rec.parse_ok       = 1'b1;
    end
    return rec;
  endfunction

  function automatic void capture_byte(hdr_in_t item);
    if (captured_len == 0) packet_link_type = item.link_type;
    // saturate the length; bytes beyond the limit are dropped
    if (captured_len < MAX_PACKET_BYTES) begin
      if (captured_len < HDR_DEPTH) header_bytes[captured_len] = item.data_byte;
      captured_len++;
    end
    if (item.last_byte) begin
      pending_records.push_back(parse_five_tuple(captured_len, packet_link_type));
      captured_len = 0;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Checking
  // --------------------------------------------------------------------------
  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s: got %h, expected %h", name, got, want));
  endtask

  task automatic check_record(hdr_out_t got);
    hdr_out_t want;
    if (pending_records.size() == 0) begin
      report_mismatch("record with no packet pending");
      return;
    end
    want = pending_records.pop_front();
    check_field("parse_ok", got.parse_ok, want.parse_ok);
    check_field("ip_protocol", got.ip_protocol, want.ip_protocol);
    check_field("source_address", got.source_address, want.source_address);
    check_field("dest_address", got.dest_address, want.dest_address);
    check_field("source_port", got.source_port, want.source_port);
    check_field("dest_port", got.dest_port, want.dest_port);
    check_field("tcp_sequence", got.tcp_sequence, want.tcp_sequence);
    check_field("tcp_flag_bits", got.tcp_flag_bits, want.tcp_flag_bits);
    check_field("payload_offset", got.payload_offset, want.payload_offset);
    check_field("payload_length", got.payload_length, want.payload_length);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && in_ready_o) capture_byte(in_data);
      if (out_valid_o && out_ready) check_record(out_data_o);
    end
  end

  // --------------------------------------------------------------------------
  // Packet construction
  // --------------------------------------------------------------------------
  function automatic logic [7:0] fill_byte();
    case (fill_mode)
      FILL_ONES:  return 8'hFF;
      FILL_ZEROS: return 8'h00;
      default:    return 8'($urandom);
    endcase
  endfunction

  function automatic void put_rand(int n);
    for (int i = 0; i < n; i++) frame_bytes.push_back(fill_byte());
  endfunction

  function automatic void put_eth(logic [15:0] et);
    put_rand(12);
    frame_bytes.push_back(et[15:8]);
    frame_bytes.push_back(et[7:0]);
  endfunction

  function automatic void put_vlan(logic [15:0] et);
    put_eth(ET_VLAN);
    put_rand(2);
    frame_bytes.push_back(et[15:8]);
    frame_bytes.push_back(et[7:0]);
  endfunction

  function automatic void put_null(logic [31:0] family);
    for (int i = 0; i < 4; i++) frame_bytes.push_back(family[8 * i +: 8]);
  endfunction

  // IP header, transport header and payload
  function automatic void put_l3l4(bit v6, logic [7:0] proto, logic [3:0] ihl,
                                   logic [3:0] doff, int payload);
    logic [7:0] b;
    if (v6) begin
      b = fill_byte();
      frame_bytes.push_back({4'd6, b[3:0]});
      put_rand(5);
      frame_bytes.push_back(proto);
      put_rand(33);
    end else begin
      frame_bytes.push_back({4'd4, ihl});
      put_rand(8);
      frame_bytes.push_back(proto);
      put_rand(10);
      if (ihl > 4'd5) put_rand(int'(ihl) * 4 - 20);
    end
    if (proto == PROTO_TCP) begin
      put_rand(12);
      b = fill_byte();
      frame_bytes.push_back({doff, b[3:0]});
      put_rand(7);
      if (doff > 4'd5) put_rand(int'(doff) * 4 - 20);
    end else begin
      put_rand(8);
    end
    put_rand(payload);
  endfunction

  function automatic void trim_to(int unsigned n);
    while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
  endfunction

  function automatic void make_random_packet(output logic [15:0] lt);
    int unsigned pick, ip_at, mode;
    bit          v6, broken;
    logic [7:0]  proto, b;
    logic [3:0]  ihl, doff;
    logic [15:0] et;
    logic [31:0] family;
    frame_bytes.delete();
    pick   = $urandom_range(99);
    broken = ($urandom_range(99) < 25);
    v6     = ($urandom_range(2) == 0);
    if (pick >= 92) begin
      lt = 16'($urandom);
      put_rand($urandom_range(1, 40));
      return;
    end
    if (pick < 40) begin
      lt = LT_ETHERNET;
      et = v6 ? ET_IPV6 : ET_IPV4;
      if (broken && $urandom_range(3) == 0) et = 16'($urandom);
      if ($urandom_range(3) == 0) put_vlan(et);
      else put_eth(et);
    end else if (pick < 52) begin
      lt = LT_NULL;
      case ($urandom_range(2))
        0:       family = AF_INET6_BSD;
        1:       family = AF_INET6_FREEBSD;
        default: family = AF_INET6_DARWIN;
      endcase
      if (!v6) family = AF_INET;
      if (broken && $urandom_range(3) == 0) family = $urandom_range(40);
      put_null(family);
    end else if (pick < 60) begin
      lt = LT_RAW;
    end else if (pick < 68) begin
      lt = LT_IPV4;
    end else if (pick < 76) begin
      lt = LT_IPV6;
    end else begin
      lt = ($urandom_range(1) == 0) ? 16'($urandom_range(2, 100)) :
                                      16'($urandom_range(230, 65535));
      v6 = broken && ($urandom_range(1) == 0);
    end

    pick = $urandom_range(9);
    proto = (pick < 5) ? PROTO_TCP : (pick < 9) ? PROTO_UDP : 8'($urandom);
    ihl  = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    doff = ($urandom_range(3) == 0) ? 4'($urandom_range(6, 15)) : 4'd5;
    mode = broken ? $urandom_range(3) : 4;
    if (mode == 0) ihl = 4'($urandom_range(4));
    if (mode == 1) doff = 4'($urandom_range(4));
    ip_at = frame_bytes.size();
    put_l3l4(v6, proto, ihl, doff,
             ($urandom_range(7) == 0) ? $urandom_range(100) : $urandom_range(12));
    if (mode == 2) begin
      b = frame_bytes[ip_at];
      b[7:4] = 4'($urandom);
      frame_bytes[ip_at] = b;
    end
    if (broken && $urandom_range(1) == 0) trim_to($urandom_range(1, frame_bytes.size()));
  endfunction

  // --------------------------------------------------------------------------
  // Driving
  // --------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b, logic [15:0] lt, logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= hdr_in_t'{data_byte: b, link_type: lt, last_byte: last};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Link type matters on the first byte only; randomize it elsewhere
  task automatic send_packet(logic [15:0] lt);
    int unsigned n;
    n = frame_bytes.size();
    for (int unsigned i = 0; i < n; i++)
      send_byte(frame_bytes[i], (i == 0) ? lt : 16'($urandom), i == n - 1);
    frame_bytes.delete();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_link_layers();
    put_eth(ET_IPV4); put_l3l4(0, PROTO_TCP, 5, 5, 6); send_packet(LT_ETHERNET);
    put_eth(ET_IPV6); put_l3l4(1, PROTO_UDP, 5, 5, 3); send_packet(LT_ETHERNET);
    put_vlan(ET_IPV4); put_l3l4(0, PROTO_UDP, 7, 5, 0); send_packet(LT_ETHERNET);
    put_vlan(ET_IPV6); put_l3l4(1, PROTO_TCP, 5, 8, 4); send_packet(LT_ETHERNET);
    put_null(AF_INET); put_l3l4(0, PROTO_TCP, 5, 5, 2); send_packet(LT_NULL);
    put_null(AF_INET6_BSD); put_l3l4(1, PROTO_UDP, 5, 5, 1); send_packet(LT_NULL);
    put_null(AF_INET6_FREEBSD); put_l3l4(1, PROTO_TCP, 5, 5, 0); send_packet(LT_NULL);
    put_null(AF_INET6_DARWIN); put_l3l4(1, PROTO_UDP, 5, 5, 5); send_packet(LT_NULL);
    put_null(AF_UNKNOWN); put_l3l4(0, PROTO_TCP, 5, 5, 2); send_packet(LT_NULL);
    put_l3l4(0, PROTO_UDP, 5, 5, 4); send_packet(LT_RAW);
    put_l3l4(1, PROTO_TCP, 5, 6, 2); send_packet(LT_RAW);
    put_l3l4(0, PROTO_TCP, 9, 5, 1); send_packet(LT_IPV4);
    put_l3l4(1, PROTO_UDP, 5, 5, 0); send_packet(LT_IPV6);
    // fallback link: IPv4 accepted, IPv6 rejected
    put_l3l4(0, PROTO_TCP, 5, 5, 3); send_packet(16'($urandom_range(230, 65535)));
    put_l3l4(1, PROTO_TCP, 5, 5, 3); send_packet(16'($urandom_range(2, 100)));
    wait_drained();
  endtask

  task automatic test_special_cases();
    // other protocols keep protocol and addresses
    put_eth(ET_IPV4); put_l3l4(0, PROTO_ICMP, 5, 5, 8); send_packet(LT_ETHERNET);
    put_eth(ET_IPV6); put_l3l4(1, PROTO_ICMPV6, 5, 5, 8); send_packet(LT_ETHERNET);
    // failed checks at each layer
    put_eth(ET_IPV4); put_l3l4(0, PROTO_TCP, 4, 5, 4); send_packet(LT_ETHERNET);
    put_eth(ET_IPV4); put_l3l4(0, PROTO_TCP, 15, 5, 0); trim_to(54);
    send_packet(LT_ETHERNET);
    put_eth(ET_IPV4); put_l3l4(0, PROTO_TCP, 5, 4, 4); send_packet(LT_ETHERNET);
    put_eth(ET_IPV4); put_l3l4(0, PROTO_TCP, 5, 15, 0); trim_to(74);
    send_packet(LT_ETHERNET);
    put_eth(ET_IPV4); put_l3l4(0, PROTO_TCP, 5, 5, 0); trim_to(53);
    send_packet(LT_ETHERNET);
    put_eth(ET_IPV4); put_l3l4(0, PROTO_UDP, 5, 5, 0); trim_to(41);
    send_packet(LT_ETHERNET);
    put_eth(ET_IPV4); put_l3l4(0, PROTO_UDP, 5, 5, 0); trim_to(34);
    send_packet(LT_ETHERNET);
    put_eth(ET_ARP); put_rand(28); send_packet(LT_ETHERNET);
    put_rand(13); send_packet(LT_ETHERNET);
    put_vlan(ET_IPV4); trim_to(17); send_packet(LT_ETHERNET);
    put_rand(3); send_packet(LT_NULL);
    wait_drained();
  endtask

  task automatic test_extremes();
    // deepest header: tag, longest IPv4 and TCP headers
    fill_mode = FILL_ONES;
    put_vlan(ET_IPV4); put_l3l4(0, PROTO_TCP, 15, 15, 0); send_packet(LT_ETHERNET);
    put_l3l4(1, PROTO_UDP, 5, 5, 2); send_packet(LT_RAW);
    put_rand(60); send_packet(16'hFFFF);
    fill_mode = FILL_ZEROS;
    put_vlan(ET_IPV6); put_l3l4(1, PROTO_UDP, 5, 5, 0); send_packet(LT_ETHERNET);
    put_rand(40); send_packet(LT_NULL);
    fill_mode = FILL_RANDOM;
    frame_bytes.push_back(8'h45); send_packet(LT_RAW);
    wait_drained();
  endtask

  task automatic test_backpressure();
    logic [15:0] lt;
    idle_pct = 0;
    stall_pct = 0;
    fork
      begin
        hold_off <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk_i);
        hold_off <= 1'b0;
      end
    join_none
    // short packets fill both pipeline registers while the output is held
    for (int i = 0; i < 24; i++) begin
      put_rand($urandom_range(1, 4));
      send_packet(16'($urandom));
    end
    for (int i = 0; i < 6; i++) begin
      make_random_packet(lt);
      send_packet(lt);
    end
    wait_drained();
    for (int i = 0; i < 4; i++) begin
      make_random_packet(lt);
      send_packet(lt);
    end
    wait_drained();
  endtask

  task automatic test_random_traffic();
    int unsigned idle_plan[4]  = '{0, 70, 0, 19};
    int unsigned stall_plan[4] = '{0, 0, 70, 19};
    int unsigned bytes_sent, packets_sent;
    logic [15:0] lt;
    for (int p = 0; p < 4; p++) begin
      idle_pct = idle_plan[p];
      stall_pct = stall_plan[p];
      bytes_sent = 0;
      packets_sent = 0;
      while (bytes_sent < 312 && packets_sent < 12) begin
        make_random_packet(lt);
        bytes_sent += frame_bytes.size();
        packets_sent++;
        send_packet(lt);
      end
    end
    wait_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_link_layers();
    test_special_cases();
    test_extremes();
    test_backpressure();
    test_random_traffic();
    idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    repeat (DRAIN_TAIL) @(posedge clk_i);
    if (pending_records.size() != 0)
      report_mismatch($sformatf("%0d records never arrived", pending_records.size()));
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
